// ----- rtl/core/stp_pkg.sv -----
`timescale 1ns / 1ps

package stp_pkg;

    localparam int ID_W   = 16;
    localparam int DIST_W = 8;
    localparam int PORT_W = 3;
    localparam int RPI_W  = 4;
    localparam int PACK_W = 16;
    localparam int PACK_PORTS = 8;

    typedef logic [1:0] t_role;

    localparam t_role ROLE_DES  = 2'd0;
    localparam t_role ROLE_ROOT = 2'd1;
    localparam t_role ROLE_BLK  = 2'd2;

    localparam logic [RPI_W-1:0] PORT_NONE = 4'd8;

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_MSG   = 1'b1;

    localparam logic CFG_OWN_ID = 1'b0;
    localparam logic CFG_PORTS  = 1'b1;

    localparam logic [3:0] PORTS_RESET = 4'd8;

    typedef struct packed {
        logic              cmd;
        logic [ID_W-1:0]   root_id;
        logic [DIST_W-1:0] distance;
        logic [ID_W-1:0]   sender_id;
        logic [PORT_W-1:0] port;
    } t_msg;

    typedef struct packed {
        logic [ID_W-1:0]   best_root;
        logic [DIST_W-1:0] best_distance;
        logic [ID_W-1:0]   best_sender;
        logic              root_flag;
        logic [RPI_W-1:0]  root_idx;
    } t_bridge;

    typedef struct packed {
        logic              changed;
        logic [PACK_W-1:0] roles_packed;
        logic [RPI_W-1:0]  root_idx_out;
        logic [ID_W-1:0]   root_id_out;
        logic [DIST_W-1:0] distance_out;
        logic              is_root_out;
    } t_result;

endpackage

// ----- rtl/core/stp_next.sv -----
`timescale 1ns / 1ps

module stp_next #(
    parameter int NUM_PORTS = 8
) (
    input  stp_pkg::t_msg                       i_msg,
    input  stp_pkg::t_bridge                    i_state,
    input  stp_pkg::t_role [NUM_PORTS-1:0]      i_roles,
    input  logic [stp_pkg::ID_W-1:0]            i_own_id,
    input  logic [3:0]                          i_ports_in_use,
    output stp_pkg::t_bridge                    o_state,
    output stp_pkg::t_role [NUM_PORTS-1:0]      o_roles,
    output stp_pkg::t_result                    o_result
);

    localparam logic [4:0] NP = 5'(NUM_PORTS);
    localparam int PK = (NUM_PORTS < stp_pkg::PACK_PORTS) ? NUM_PORTS : stp_pkg::PACK_PORTS;

    logic [4:0]                    w_n;
    logic                          w_in_range;
    logic [4:0]                    w_port5;
    stp_pkg::t_role                w_cur_role;
    logic [stp_pkg::DIST_W:0]      w_d1;
    logic                          w_better;
    logic                          w_rule5;
    logic                          w_any_des;
    logic                          w_any_root;
    logic [NUM_PORTS-1:0]          w_last;
    logic                          w_changed;
    logic [stp_pkg::PACK_W-1:0]    w_packed;
    stp_pkg::t_bridge              w_ns;
    stp_pkg::t_role [NUM_PORTS-1:0] w_nr;

    always_comb begin
        if (i_ports_in_use == 4'd0) begin
            w_n = 5'd1;
        end else if ({1'b0, i_ports_in_use} > NP) begin
            w_n = NP;
        end else begin
            w_n = {1'b0, i_ports_in_use};
        end
        w_port5    = {2'b00, i_msg.port};
        w_in_range = w_port5 < w_n;
        w_cur_role = stp_pkg::ROLE_DES;
        for (int p = 0; p < NUM_PORTS; p++) begin
            if (w_port5 == 5'(p)) w_cur_role = i_roles[p];
        end
        w_d1 = {1'b0, i_msg.distance} + 9'd1;
        w_better = (i_msg.root_id < i_state.best_root) ||
                   ((i_msg.root_id == i_state.best_root) &&
                    (w_d1 < {1'b0, i_state.best_distance})) ||
                   ((i_msg.root_id == i_state.best_root) &&
                    (w_d1 == {1'b0, i_state.best_distance}) &&
                    (i_msg.sender_id < i_state.best_sender));
        w_rule5 = (i_msg.root_id == i_state.best_root) &&
                  (w_cur_role == stp_pkg::ROLE_DES) &&
                  ((i_msg.distance < i_state.best_distance) ||
                   ((i_msg.distance == i_state.best_distance) &&
                    (i_msg.sender_id < i_own_id)));

        w_ns       = i_state;
        w_nr       = i_roles;
        w_changed  = 1'b0;
        w_any_des  = 1'b0;
        w_any_root = 1'b0;
        w_last     = '0;

        if (i_msg.cmd == stp_pkg::CMD_START) begin
            w_ns.best_root     = i_own_id;
            w_ns.best_distance = '0;
            w_ns.best_sender   = i_own_id;
            w_ns.root_flag     = 1'b1;
            w_ns.root_idx      = stp_pkg::PORT_NONE;
            w_nr               = '0;
        end else if (w_in_range) begin
            if (w_better) begin
                w_nr               = '0;
                w_ns.best_root     = i_msg.root_id;
                w_ns.best_distance = w_d1[stp_pkg::DIST_W] ? '1 : w_d1[stp_pkg::DIST_W-1:0];
                w_ns.root_flag     = 1'b0;
                w_ns.best_sender   = i_msg.sender_id;
                w_ns.root_idx      = {1'b0, i_msg.port};
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (w_port5 == 5'(p)) w_nr[p] = stp_pkg::ROLE_ROOT;
                end
                w_changed = 1'b1;
            end else if (w_rule5) begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (w_port5 == 5'(p)) w_nr[p] = stp_pkg::ROLE_BLK;
                end
                w_changed = 1'b1;
            end
            // leaf check: highest root port wins
            for (int p = 0; p < NUM_PORTS; p++) begin
                if (5'(p) < w_n) begin
                    if (w_nr[p] == stp_pkg::ROLE_DES) w_any_des = 1'b1;
                    if (w_nr[p] == stp_pkg::ROLE_ROOT) begin
                        w_any_root = 1'b1;
                        w_last     = '0;
                        w_last[p]  = 1'b1;
                    end
                end
            end
            if (!w_any_des && w_any_root) begin
                for (int p = 0; p < NUM_PORTS; p++) begin
                    if (w_last[p]) w_nr[p] = stp_pkg::ROLE_BLK;
                end
                w_ns.root_idx = stp_pkg::PORT_NONE;
            end
        end

        w_packed = '0;
        for (int p = 0; p < PK; p++) begin
            if (5'(p) < w_n) w_packed[2*p +: 2] = w_nr[p];
        end
    end

    assign o_state = w_ns;
    assign o_roles = w_nr;

    always_comb begin
        o_result.changed       = w_changed;
        o_result.roles_packed  = w_packed;
        o_result.root_idx_out  = w_ns.root_idx;
        o_result.root_id_out   = w_ns.best_root;
        o_result.distance_out  = w_ns.best_distance;
        o_result.is_root_out   = w_ns.root_flag;
    end

endmodule

// ----- rtl/core/spanning_tree_port_roles.sv -----
`timescale 1ns / 1ps
// Channel  | Dir | Signals                        | Word
// s        | in  | i_s_tvalid/o_s_tready          | tdata + tuser command
// m        | out | o_m_tvalid/i_m_tready          | tdata
// cfg      | in  | i_cfg_wr_en/i_cfg_index        | i_cfg_data
//
// One word per cycle sustained while the output takes results. Input register,
// then result register written together with the bridge state.
// Bridge state updates as a word moves into the result register.
// Reset: synchronous, active low; bridge is own root, all ports designated.
// A stalled output holds one result and one word in the input register.

module spanning_tree_port_roles #(
    parameter int NUM_PORTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // root_id[15:0], distance[23:16], sender_id[39:24], port[42:40], zero pad
    input  logic [47:0] i_s_tdata,
    // command[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // changed[0], roles_packed[16:1], root_idx_out[20:17], root_id_out[36:21],
    // distance_out[44:37], is_root_out[45], zero pad
    output logic [47:0] o_m_tdata,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    stp_pkg::t_msg                    r_in;
    logic                             r_in_vld;
    stp_pkg::t_bridge                 r_state;
    stp_pkg::t_role [NUM_PORTS-1:0]   r_roles;
    stp_pkg::t_result                 r_res;
    logic                             r_out_vld;
    logic [stp_pkg::ID_W-1:0]         r_own_id;
    logic [3:0]                       r_ports_in_use;

    stp_pkg::t_bridge                 n_state;
    stp_pkg::t_role [NUM_PORTS-1:0]   n_roles;
    stp_pkg::t_result                 n_res;

    logic                             w_s_acc;
    logic                             w_adv;
    logic [NUM_PORTS-1:0]             w_root_mask;

    assign w_adv      = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_s_acc    = i_s_tvalid && o_s_tready;

    stp_next #(
        .NUM_PORTS (NUM_PORTS)
    ) u_next (
        .i_msg          (r_in),
        .i_state        (r_state),
        .i_roles        (r_roles),
        .i_own_id       (r_own_id),
        .i_ports_in_use (r_ports_in_use),
        .o_state        (n_state),
        .o_roles        (n_roles),
        .o_result       (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_id       <= '0;
            r_ports_in_use <= stp_pkg::PORTS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                stp_pkg::CFG_OWN_ID: r_own_id       <= i_cfg_data;
                stp_pkg::CFG_PORTS:  r_ports_in_use <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_s_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_adv) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_in.cmd       <= i_s_tuser;
            r_in.root_id   <= i_s_tdata[15:0];
            r_in.distance  <= i_s_tdata[23:16];
            r_in.sender_id <= i_s_tdata[39:24];
            r_in.port      <= i_s_tdata[42:40];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.best_root     <= '0;
            r_state.best_distance <= '0;
            r_state.best_sender   <= '0;
            r_state.root_flag     <= 1'b1;
            r_state.root_idx      <= stp_pkg::PORT_NONE;
            r_roles               <= '0;
            r_out_vld             <= 1'b0;
        end else if (w_adv) begin
            r_state   <= n_state;
            r_roles   <= n_roles;
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_res <= n_res;
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {2'b00, r_res.is_root_out, r_res.distance_out, r_res.root_id_out,
                         r_res.root_idx_out, r_res.roles_packed, r_res.changed};

    always_comb begin
        for (int p = 0; p < NUM_PORTS; p++) begin
            w_root_mask[p] = (r_roles[p] == stp_pkg::ROLE_ROOT);
        end
    end

    a_root_no_port: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.root_flag |-> (r_state.root_idx == stp_pkg::PORT_NONE))
        else $error("own root with a root port");

    a_one_root_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_root_mask) <= 1)
        else $error("more than one root port role");

    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_out_vld && !i_m_tready) |=> (r_in_vld && $stable(r_in)))
        else $error("buffered word lost under stall");

    a_state_with_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_state) |-> o_m_tvalid)
        else $error("state moved without a result");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int NPORTS = 8;

    class bridge_tracker;
        logic [stp_pkg::ID_W-1:0]   own_id;
        logic [3:0]                 port_cfg;
        logic [stp_pkg::ID_W-1:0]   best_root;
        logic [stp_pkg::DIST_W-1:0] best_dist;
        logic [stp_pkg::ID_W-1:0]   best_sender;
        logic                       is_root;
        logic [stp_pkg::RPI_W-1:0]  root_idx;
        stp_pkg::t_role             role [NPORTS];
        stp_pkg::t_result           pending [$];
        int                         errors;

        function new();
            own_id      = '0;
            port_cfg    = stp_pkg::PORTS_RESET;
            best_root   = '0;
            best_dist   = '0;
            best_sender = '0;
            is_root     = 1'b1;
            root_idx    = stp_pkg::PORT_NONE;
            foreach (role[p]) role[p] = stp_pkg::ROLE_DES;
            errors      = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] val);
            if (idx == stp_pkg::CFG_OWN_ID) own_id = val;
            else port_cfg = val[3:0];
        endfunction

        function int eff_ports();
            int n;
            n = port_cfg;
            if (n < 1) n = 1;
            if (n > NPORTS) n = NPORTS;
            return n;
        endfunction

        function void note_message(stp_pkg::t_msg m);
            int                         n;
            int                         des;
            int                         roots;
            int                         last;
            logic [8:0]                 d1;
            logic                       better;
            logic                       chg;
            logic [stp_pkg::PACK_W-1:0] role_bits;
            stp_pkg::t_result           want;
            n   = eff_ports();
            chg = 1'b0;
            if (m.cmd == stp_pkg::CMD_START) begin
                best_root   = own_id;
                best_dist   = '0;
                best_sender = own_id;
                is_root     = 1'b1;
                root_idx    = stp_pkg::PORT_NONE;
                foreach (role[p]) role[p] = stp_pkg::ROLE_DES;
            end else if (int'(m.port) < n) begin
                d1 = {1'b0, m.distance} + 9'd1;
                better = (m.root_id < best_root) ||
                         (m.root_id == best_root && d1 < {1'b0, best_dist}) ||
                         (m.root_id == best_root && d1 == {1'b0, best_dist} &&
                          m.sender_id < best_sender);
                if (better) begin
                    foreach (role[p]) role[p] = stp_pkg::ROLE_DES;
                    best_root   = m.root_id;
                    best_dist   = d1[8] ? 8'hff : d1[7:0];
                    is_root     = 1'b0;
                    best_sender = m.sender_id;
                    root_idx    = {1'b0, m.port};
                    role[m.port] = stp_pkg::ROLE_ROOT;
                    chg = 1'b1;
                end else if (m.root_id == best_root && role[m.port] == stp_pkg::ROLE_DES &&
                             (m.distance < best_dist ||
                              (m.distance == best_dist && m.sender_id < own_id))) begin
                    role[m.port] = stp_pkg::ROLE_BLK;
                    chg = 1'b1;
                end
                // leaf check: nothing designated left, so drop the root port
                des   = 0;
                roots = 0;
                last  = 0;
                for (int p = 0; p < n; p++) begin
                    if (role[p] == stp_pkg::ROLE_DES) des++;
                    if (role[p] == stp_pkg::ROLE_ROOT) begin
                        roots++;
                        last = p;
                    end
                end
                if (des == 0 && roots != 0) begin
                    role[last] = stp_pkg::ROLE_BLK;
                    root_idx   = stp_pkg::PORT_NONE;
                end
            end
            role_bits = '0;
            for (int p = 0; p < n && p < stp_pkg::PACK_PORTS; p++)
                role_bits[2*p +: 2] = role[p];
            want.changed       = chg;
            want.roles_packed  = role_bits;
            want.root_idx_out  = root_idx;
            want.root_id_out   = best_root;
            want.distance_out  = best_dist;
            want.is_root_out   = is_root;
            pending.push_back(want);
        endfunction

        function void check_result(logic [47:0] w);
            stp_pkg::t_result got;
            stp_pkg::t_result want;
            got.changed       = w[0];
            got.roles_packed  = w[16:1];
            got.root_idx_out  = w[20:17];
            got.root_id_out   = w[36:21];
            got.distance_out  = w[44:37];
            got.is_root_out   = w[45];
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: word with nothing outstanding: %h", $realtime, w);
                return;
            end
            want = pending.pop_front();
            if (got.changed !== want.changed || got.roles_packed !== want.roles_packed ||
                got.root_idx_out !== want.root_idx_out ||
                got.root_id_out !== want.root_id_out ||
                got.distance_out !== want.distance_out ||
                got.is_root_out !== want.is_root_out) begin
                errors++;
                if (errors <= 10) begin
                    $display("%0t: mismatch exp chg=%0d roles=%h rp=%0d root=%h dist=%0d own=%0d",
                             $realtime, want.changed, want.roles_packed, want.root_idx_out,
                             want.root_id_out, want.distance_out, want.is_root_out);
                    $display("%0t:          got chg=%0d roles=%h rp=%0d root=%h dist=%0d own=%0d",
                             $realtime, got.changed, got.roles_packed, got.root_idx_out,
                             got.root_id_out, got.distance_out, got.is_root_out);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_s_tvalid  = 1'b0;
    logic [47:0] i_s_tdata   = '0;
    logic        i_s_tuser   = 1'b0;
    logic        i_m_tready  = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data  = '0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [47:0] o_m_tdata;

    bridge_tracker tracker = new();
    bit            calm    = 1'b0;
    bit            hold_req = 1'b0;

    spanning_tree_port_roles #(.NUM_PORTS(NPORTS)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) tracker.check_result(o_m_tdata);
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                i_m_tready <= 1'b0;
                repeat (60) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end
        end
    end

    function automatic stp_pkg::t_msg mk_msg(logic cmd, logic [15:0] rid, logic [7:0] dist_val,
                                              logic [15:0] sid, logic [2:0] port);
        stp_pkg::t_msg m;
        m.cmd       = cmd;
        m.root_id   = rid;
        m.distance  = dist_val;
        m.sender_id = sid;
        m.port      = port;
        return m;
    endfunction

    // mostly messages close to the current best, so that the tie rules get exercised
    function automatic stp_pkg::t_msg pick_msg();
        stp_pkg::t_msg m;
        int            kind;
        int            d;
        logic [15:0]   r;
        logic [15:0]   s;
        kind = $urandom_range(0, 99);
        if (kind < 4)
            return mk_msg(stp_pkg::CMD_START, 16'($urandom), 8'($urandom), 16'($urandom),
                          3'($urandom));
        if (kind < 10)
            return mk_msg(stp_pkg::CMD_MSG, 16'($urandom), 8'($urandom), 16'($urandom),
                          3'($urandom));
        case ($urandom_range(0, 7))
            0, 1, 2, 3: r = tracker.best_root;
            4:          r = tracker.best_root - (tracker.best_root != 0);
            5:          r = tracker.best_root + 16'd1;
            6:          r = tracker.own_id - 16'($urandom_range(0, 3));
            default:    r = 16'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0:       d = 255;
            1:       d = 254;
            default: d = int'(tracker.best_dist) + $urandom_range(0, 2) - 1;
        endcase
        if (d < 0) d = 0;
        if (d > 255) d = 255;
        case ($urandom_range(0, 5))
            0, 1, 2: s = tracker.own_id + 16'($urandom_range(0, 2)) - 16'd1;
            3:       s = tracker.best_sender;
            default: s = 16'($urandom);
        endcase
        m = mk_msg(stp_pkg::CMD_MSG, r, 8'(d), s,
                   3'($urandom_range(0, tracker.eff_ports() - 1)));
        if ($urandom_range(0, 9) == 0) m.port = 3'($urandom_range(0, 7));
        return m;
    endfunction

    task automatic send_msg(stp_pkg::t_msg m);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, m.port, m.sender_id, m.distance, m.root_id};
        i_s_tuser  <= m.cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        tracker.note_message(m);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (tracker.pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] own, logic [15:0] ports);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= stp_pkg::CFG_OWN_ID;
        i_cfg_data  <= own;
        @(posedge i_clk);
        tracker.set_reg(stp_pkg::CFG_OWN_ID, own);
        i_cfg_index <= stp_pkg::CFG_PORTS;
        i_cfg_data  <= ports;
        @(posedge i_clk);
        tracker.set_reg(stp_pkg::CFG_PORTS, ports);
        i_cfg_wr_en <= 1'b0;
    endtask

    logic [15:0] own_tab [7];
    logic [3:0]  port_tab [7];

    initial begin
        own_tab  = '{16'h0, 16'hffff, 16'h0000, 16'h0, 16'h0, 16'h0001, 16'h0};
        port_tab = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd2, 4'd3, 4'd8};
        foreach (own_tab[k]) if (own_tab[k] == 16'h0 && k != 2) own_tab[k] = 16'($urandom);
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_regs(16'h8000, 16'h0004);

        // directed: tie rules, blocking, leaf check, ignored ports, distance at its top
        send_msg(mk_msg(stp_pkg::CMD_START, 16'hffff, 8'hff, 16'hffff, 3'd7));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd2, 16'h2000, 3'd1));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd1, 16'h2000, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd1, 16'h1fff, 3'd2));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd1, 16'h9000, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd1, 16'h9000, 3'd1));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h1000, 8'd2, 16'h0001, 3'd3));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h0000, 8'd0, 16'h0000, 3'd5));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h0000, 8'd0, 16'h0000, 3'd7));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h0000, 8'hff, 16'hffff, 3'd3));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h0000, 8'hfe, 16'hffff, 3'd2));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h0000, 8'hff, 16'h0000, 3'd1));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'hffff, 8'h00, 16'h0000, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_START, 16'h0000, 8'h00, 16'h0000, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'hffff, 8'h00, 16'h0000, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h8000, 8'h00, 16'h7fff, 3'd0));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h8000, 8'h00, 16'h7fff, 3'd1));
        send_msg(mk_msg(stp_pkg::CMD_MSG, 16'h7fff, 8'hff, 16'hffff, 3'd2));
        drain();

        for (int ph = 0; ph < 7; ph++) begin
            set_regs(own_tab[ph], (16'($urandom) & 16'hfff0) | {12'b0, port_tab[ph]});
            if (ph == 1) hold_req = 1'b1;
            if (ph == 6) calm = 1'b1;
            repeat (265) send_msg(pick_msg());
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/stp_pkg.sv
rtl/core/stp_next.sv
rtl/core/spanning_tree_port_roles.sv
tb/testbench.sv
